FILE: rtl/vlan_port_list_parser_core_assert.svh
// ----------------------------------------------------------------------------
// VLAN port list parser - assertion macros
// Concurrent assertion helpers; they compile away when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef VLAN_PORT_LIST_PARSER_CORE_ASSERT_SVH
`define VLAN_PORT_LIST_PARSER_CORE_ASSERT_SVH

`ifndef SYNTHESIS

// same-cycle implication
`define VPL_ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("vpl assertion failed");

// next-cycle implication
`define VPL_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("vpl assertion failed");

`else

`define VPL_ASSERT_NOW(label, clk, rst_n, ante, cons)
`define VPL_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

FILE: rtl/vpl_pkg.sv
// ----------------------------------------------------------------------------
// VLAN port list parser - package
// Parser mode codes, character codes and register indexes.
// ----------------------------------------------------------------------------
package vpl_pkg;

	// parser modes
	localparam logic [1:0] MODE_SKIP    = 2'd0;
	localparam logic [1:0] MODE_NUM     = 2'd1;
	localparam logic [1:0] MODE_SUFFIX  = 2'd2;
	localparam logic [1:0] MODE_INVALID = 2'd3;

	// character codes
	localparam logic [7:0] CH_NUL   = 8'h00;
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_LF    = 8'h0a;
	localparam logic [7:0] CH_CR    = 8'h0d;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_STAR  = 8'h2a;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NINE  = 8'h39;
	localparam logic [7:0] CH_T     = 8'h74;
	localparam logic [7:0] CH_U     = 8'h75;

	// configuration register indexes
	localparam logic REG_CPU_PORT   = 1'b0;
	localparam logic REG_PORT_COUNT = 1'b1;

	// port number accumulator
	localparam int          NUM_W     = 10;
	localparam logic [9:0]  NUM_LIMIT = 10'd1023;

	typedef logic [NUM_W-1:0] port_num_t;

endpackage

FILE: rtl/vlan_port_list_parser_core.sv
// ----------------------------------------------------------------------------
// VLAN port list parser - top level
// Parses a text port list such as "1 2 3 4 5*" one byte per beat and returns
// the member, untagged and default-VLAN port masks when the string ends.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (char_in, in_valid/in_ready) takes one text byte per beat.
//   A NUL byte ends the string; in the next cycle a result beat (list_ok and the
//   three 32-bit masks) appears on the output channel (out_valid/out_ready).
//   Other bytes produce no result.
//   Throughput is one byte per cycle while in_ready is high: the parse state is
//   updated by a single level of logic (a multiply by ten and a saturate on the
//   port number) and the result sits in an output register, but bytes stop
//   flowing while a finished result waits and out_ready is low.
//   in_ready drops only while a result is held and out_ready is low; then
//   nothing is accepted until the result beat is taken.
//   Reset clears the parse state, empties the output register and sets
//   cpu_port to 0 and port_count to 32. The config port (cfg_we, cfg_index,
//   cfg_data) writes a register; the user must use it only while idle, as the block does not enforce it.
//   After a result the parser starts over for the next string.
// ----------------------------------------------------------------------------
`include "vlan_port_list_parser_core_assert.svh"

module vlan_port_list_parser_core #(
	parameter int MAX_PORTS = 32
) (
	input  logic        clk,
	input  logic        arst_n,

	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [5:0]  cfg_data,

	input  logic [7:0]  char_in,
	input  logic        in_valid,
	output logic        in_ready,

	output logic        list_ok,
	output logic [31:0] member_mask,
	output logic [31:0] untagged_mask,
	output logic [31:0] default_vlan_mask,
	output logic        out_valid,
	input  logic        out_ready
);

	// only ports below 32 can ever reach the outputs
	localparam int VIEW_W = (MAX_PORTS < 32) ? MAX_PORTS : 32;

	// configuration registers
	logic [4:0] cpu_port_q;
	logic [5:0] port_count_q;

	// parse state
	logic [1:0]          mode_q;
	vpl_pkg::port_num_t  num_q;
	logic                untag_q;
	logic                dflt_q;
	logic [VIEW_W-1:0]   mem_bits_q;
	logic [VIEW_W-1:0]   utg_bits_q;
	logic [VIEW_W-1:0]   dfb_bits_q;

	// result register
	logic        res_valid_q;
	logic        res_ok_q;
	logic [31:0] res_mem_q;
	logic [31:0] res_utg_q;
	logic [31:0] res_dfb_q;

	logic accept;
	logic is_nul, is_blank, is_digit;
	logic [13:0] num_mac;
	vpl_pkg::port_num_t num_dig;
	logic [3:0] digit;

	logic [1:0]         mode_d;
	vpl_pkg::port_num_t num_d;
	logic               untag_d, dflt_d;
	logic               do_commit, do_emit;
	logic [VIEW_W-1:0]  hit;
	logic [VIEW_W-1:0]  mem_c, utg_c, dfb_c;
	logic [31:0]        cut;
	logic               ok;

	assign accept   = in_valid && in_ready;
	assign in_ready = !res_valid_q || out_ready;

	// byte classes
	always_comb begin
		is_nul   = (char_in == vpl_pkg::CH_NUL);
		is_blank = char_in inside {vpl_pkg::CH_SPACE, vpl_pkg::CH_TAB,
			vpl_pkg::CH_LF, vpl_pkg::CH_CR};
		is_digit = char_in inside {[vpl_pkg::CH_ZERO:vpl_pkg::CH_NINE]};
	end

	// next port number: num * 10 + digit, saturating
	assign digit   = 4'(char_in - vpl_pkg::CH_ZERO);
	assign num_mac = (mode_q == vpl_pkg::MODE_NUM)
		? 14'(num_q) * 14'd10 + 14'(digit) : 14'(digit);
	assign num_dig = (num_mac > 14'(vpl_pkg::NUM_LIMIT)) ? vpl_pkg::NUM_LIMIT
		: num_mac[vpl_pkg::NUM_W-1:0];

	// mode transitions
	always_comb begin
		mode_d    = mode_q;
		num_d     = num_q;
		untag_d   = untag_q;
		dflt_d    = dflt_q;
		do_commit = 1'b0;
		do_emit   = 1'b0;
		case (mode_q)
			vpl_pkg::MODE_SKIP: begin
				if (is_nul) begin
					do_emit = 1'b1;
				end else if (is_digit) begin
					num_d   = num_dig;
					untag_d = (num_dig != vpl_pkg::port_num_t'(cpu_port_q));
					dflt_d  = 1'b0;
					mode_d  = vpl_pkg::MODE_NUM;
				end else if (!is_blank) begin
					mode_d = vpl_pkg::MODE_INVALID;
				end
			end
			vpl_pkg::MODE_NUM, vpl_pkg::MODE_SUFFIX: begin
				if (mode_q == vpl_pkg::MODE_NUM && is_digit) begin
					num_d   = num_dig;
					untag_d = (num_dig != vpl_pkg::port_num_t'(cpu_port_q));
					dflt_d  = 1'b0;
				end else if (is_nul) begin
					do_commit = 1'b1;
					do_emit   = 1'b1;
				end else if (is_blank) begin
					do_commit = 1'b1;
					num_d     = '0;
					mode_d    = vpl_pkg::MODE_SKIP;
				end else begin
					// suffix byte; unknown ones are ignored
					if (char_in == vpl_pkg::CH_U) begin
						untag_d = 1'b1;
					end else if (char_in == vpl_pkg::CH_T) begin
						untag_d = 1'b0;
					end else if (char_in == vpl_pkg::CH_STAR) begin
						dflt_d = 1'b1;
					end
					mode_d = vpl_pkg::MODE_SUFFIX;
				end
			end
			default: begin
				if (is_nul) begin
					do_emit = 1'b1;
				end
			end
		endcase
	end

	// port decode and commit into the mask bits
	always_comb begin
		for (int i = 0; i < VIEW_W; i++) begin
			hit[i] = do_commit && (num_q == vpl_pkg::NUM_W'(i));
		end
		mem_c = mem_bits_q | hit;
		utg_c = utg_bits_q | (hit & {VIEW_W{untag_q}});
		dfb_c = dfb_bits_q | (hit & {VIEW_W{dflt_q}});
	end

	// port count cut
	always_comb begin
		for (int i = 0; i < 32; i++) begin
			cut[i] = (6'(i) < port_count_q);
		end
		ok = (mode_q != vpl_pkg::MODE_INVALID);
	end

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cpu_port_q   <= '0;
			port_count_q <= 6'd32;
		end else if (cfg_we) begin
			case (cfg_index)
				vpl_pkg::REG_CPU_PORT:   cpu_port_q   <= cfg_data[4:0];
				vpl_pkg::REG_PORT_COUNT: port_count_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// parse state update
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q     <= vpl_pkg::MODE_SKIP;
			num_q      <= '0;
			untag_q    <= 1'b0;
			dflt_q     <= 1'b0;
			mem_bits_q <= '0;
			utg_bits_q <= '0;
			dfb_bits_q <= '0;
		end else if (accept) begin
			if (do_emit) begin
				mode_q     <= vpl_pkg::MODE_SKIP;
				num_q      <= '0;
				untag_q    <= 1'b0;
				dflt_q     <= 1'b0;
				mem_bits_q <= '0;
				utg_bits_q <= '0;
				dfb_bits_q <= '0;
			end else begin
				mode_q     <= mode_d;
				num_q      <= num_d;
				untag_q    <= untag_d;
				dflt_q     <= dflt_d;
				mem_bits_q <= mem_c;
				utg_bits_q <= utg_c;
				dfb_bits_q <= dfb_c;
			end
		end
	end

	// result register control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (accept && do_emit) begin
			res_valid_q <= 1'b1;
		end else if (out_ready) begin
			res_valid_q <= 1'b0;
		end
	end

	// result payload
	always_ff @(posedge clk) begin
		if (accept && do_emit) begin
			res_ok_q  <= ok;
			res_mem_q <= 32'(mem_c) & cut & {32{ok}};
			res_utg_q <= 32'(utg_c) & cut & {32{ok}};
			res_dfb_q <= 32'(dfb_c) & cut & {32{ok}};
		end
	end

	assign out_valid         = res_valid_q;
	assign list_ok           = res_ok_q;
	assign member_mask       = res_mem_q;
	assign untagged_mask     = res_utg_q;
	assign default_vlan_mask = res_dfb_q;

	// checks
	`VPL_ASSERT_NEXT(a_nul_gives_result, clk, arst_n,
		accept && is_nul, out_valid)
	`VPL_ASSERT_NEXT(a_nul_restarts, clk, arst_n,
		accept && is_nul, mode_q == vpl_pkg::MODE_SKIP && mem_bits_q == '0)
	`VPL_ASSERT_NOW(a_invalid_masks_zero, clk, arst_n,
		out_valid && !list_ok,
		member_mask == '0 && untagged_mask == '0 && default_vlan_mask == '0)
	`VPL_ASSERT_NOW(a_masks_within_members, clk, arst_n,
		out_valid,
		(untagged_mask & ~member_mask) == '0 && (default_vlan_mask & ~member_mask) == '0)

endmodule

FILE: tb/tb_vlan_port_list_parser_core.sv
// ----------------------------------------------------------------------------
// VLAN port list parser - testbench
// Streams port list strings into the core: a short directed set, then random
// phases of well-formed lists, lists with a bad token and raw byte noise, under
// several cpu_port / port_count settings and random gaps on both channels.
// A behavioral parser predicts every result beat; each field is checked.
// ----------------------------------------------------------------------------
module tb_vlan_port_list_parser_core;

	localparam int PORT_LIMIT     = 32;
	localparam int IDLE_PCT       = 23;
	localparam int WATCHDOG_LIMIT = 5000;
	localparam int PHASE_ITEMS    = 320;

	typedef struct packed {
		logic        ok;
		logic [31:0] member;
		logic [31:0] untagged;
		logic [31:0] dflt;
	} port_masks_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_we = 1'b0;
	logic        cfg_index = vpl_pkg::REG_CPU_PORT;
	logic [5:0]  cfg_data = '0;
	logic [7:0]  char_in = vpl_pkg::CH_NUL;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic        list_ok;
	logic [31:0] member_mask;
	logic [31:0] untagged_mask;
	logic [31:0] default_vlan_mask;
	logic        out_valid;
	logic        out_ready = 1'b0;

	// parser mirror and its copy of the registers
	logic [1:0]          pmode = vpl_pkg::MODE_SKIP;
	vpl_pkg::port_num_t  pnum = '0;
	logic                puntag = 1'b0;
	logic                pdflt = 1'b0;
	logic [31:0]         member_bits = '0;
	logic [31:0]         untag_bits = '0;
	logic [31:0]         dflt_bits = '0;
	logic [4:0]          cpu_port_q = 5'd0;
	logic [5:0]          port_count_q = 6'd32;

	logic [7:0]  char_stream[$];
	port_masks_t masks_due[$];
	int          mismatches = 0;
	int          idle_cycles = 0;
	bit          in_taken = 1'b0;
	bit          steady = 1'b0;

	vlan_port_list_parser_core #(
		.MAX_PORTS(PORT_LIMIT)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.char_in(char_in),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.list_ok(list_ok),
		.member_mask(member_mask),
		.untagged_mask(untagged_mask),
		.default_vlan_mask(default_vlan_mask),
		.out_valid(out_valid),
		.out_ready(out_ready)
	);

	initial forever #4 clk = ~clk;

	function automatic bit is_blank(logic [7:0] c);
		return c == vpl_pkg::CH_SPACE || c == vpl_pkg::CH_TAB || c == vpl_pkg::CH_LF
			|| c == vpl_pkg::CH_CR;
	endfunction

	function automatic bit is_digit(logic [7:0] c);
		return c >= vpl_pkg::CH_ZERO && c <= vpl_pkg::CH_NINE;
	endfunction

	function automatic logic [7:0] pick_blank();
		case ($urandom_range(3))
			0: return vpl_pkg::CH_SPACE;
			1: return vpl_pkg::CH_TAB;
			2: return vpl_pkg::CH_LF;
			default: return vpl_pkg::CH_CR;
		endcase
	endfunction

	function automatic logic [7:0] pick_suffix();
		case ($urandom_range(4))
			0: return vpl_pkg::CH_U;
			1: return vpl_pkg::CH_T;
			2: return vpl_pkg::CH_STAR;
			default: return 8'($urandom_range(8'h21, 8'h7e));
		endcase
	endfunction

	// decimal accumulate, saturating; flags restart with every digit
	function void add_digit(logic [7:0] c);
		int v;
		v = int'(pnum) * 10 + int'(c) - int'(vpl_pkg::CH_ZERO);
		if (v > int'(vpl_pkg::NUM_LIMIT))
			v = int'(vpl_pkg::NUM_LIMIT);
		pnum = v[vpl_pkg::NUM_W-1:0];
		puntag = (pnum != vpl_pkg::port_num_t'(cpu_port_q));
		pdflt = 1'b0;
	endfunction

	// ports past the mask width only consume their suffix
	function void commit_port();
		if (pnum < PORT_LIMIT && pnum < 32) begin
			member_bits[pnum[4:0]] = 1'b1;
			if (puntag)
				untag_bits[pnum[4:0]] = 1'b1;
			if (pdflt)
				dflt_bits[pnum[4:0]] = 1'b1;
		end
		pnum = '0;
	endfunction

	// end of string: queue the cut masks and start over
	function void emit_masks();
		port_masks_t m;
		logic [63:0] cut;
		cut = (64'd1 << port_count_q) - 64'd1;
		m = '0;
		if (pmode != vpl_pkg::MODE_INVALID) begin
			m.ok = 1'b1;
			m.member = member_bits & cut[31:0];
			m.untagged = untag_bits & cut[31:0];
			m.dflt = dflt_bits & cut[31:0];
		end
		masks_due.push_back(m);
		pmode = vpl_pkg::MODE_SKIP;
		pnum = '0;
		puntag = 1'b0;
		pdflt = 1'b0;
		member_bits = '0;
		untag_bits = '0;
		dflt_bits = '0;
	endfunction

	function void parse_char(logic [7:0] c);
		case (pmode)
			vpl_pkg::MODE_SKIP: begin
				if (c == vpl_pkg::CH_NUL) begin
					emit_masks();
				end else if (is_digit(c)) begin
					pnum = '0;
					add_digit(c);
					pmode = vpl_pkg::MODE_NUM;
				end else if (!is_blank(c)) begin
					pmode = vpl_pkg::MODE_INVALID;
				end
			end
			vpl_pkg::MODE_NUM, vpl_pkg::MODE_SUFFIX: begin
				if (pmode == vpl_pkg::MODE_NUM && is_digit(c)) begin
					add_digit(c);
				end else if (c == vpl_pkg::CH_NUL) begin
					commit_port();
					emit_masks();
				end else if (is_blank(c)) begin
					commit_port();
					pmode = vpl_pkg::MODE_SKIP;
				end else begin
					if (c == vpl_pkg::CH_U)
						puntag = 1'b1;
					else if (c == vpl_pkg::CH_T)
						puntag = 1'b0;
					else if (c == vpl_pkg::CH_STAR)
						pdflt = 1'b1;
					pmode = vpl_pkg::MODE_SUFFIX;
				end
			end
			default: begin
				if (c == vpl_pkg::CH_NUL)
					emit_masks();
			end
		endcase
	endfunction

	task automatic report(string what, logic [31:0] got, logic [31:0] want);
		$display("mismatch at %0t: %s got %h want %h", $time, what, got, want);
		mismatches++;
	endtask

	// monitor: check result beats first, then mirror the accepted byte
	always @(posedge clk) begin
		port_masks_t want;
		in_taken = arst_n && in_valid && in_ready;
		if (arst_n && out_valid && out_ready) begin
			if (masks_due.size() == 0) begin
				report("result beat with none due, member_mask", member_mask, '0);
			end else begin
				want = masks_due.pop_front();
				if (list_ok !== want.ok)
					report("list_ok", 32'(list_ok), 32'(want.ok));
				if (member_mask !== want.member)
					report("member_mask", member_mask, want.member);
				if (untagged_mask !== want.untagged)
					report("untagged_mask", untagged_mask, want.untagged);
				if (default_vlan_mask !== want.dflt)
					report("default_vlan_mask", default_vlan_mask, want.dflt);
			end
		end
		if (in_taken)
			parse_char(char_in);
	end

	// driver: hold a beat until taken, then maybe gap, then the next byte
	always @(negedge clk) begin
		if (!in_valid || in_taken) begin
			if (char_stream.size() != 0 && (steady || $urandom_range(99) >= IDLE_PCT)) begin
				in_valid <= 1'b1;
				char_in <= char_stream.pop_front();
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// result side back-pressure
	always @(negedge clk) begin
		out_ready <= steady || ($urandom_range(99) >= IDLE_PCT);
	end

	// watchdog on cycles without any handshake
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready) || cfg_we)
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("** vlan_port_list_parser_core: FAILED **");
			$finish;
		end
	end

	task automatic push_text(string s);
		foreach (s[i])
			char_stream.push_back(s[i]);
	endtask

	task automatic cfg_write(logic idx, logic [5:0] value);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		@(negedge clk);
		cfg_we <= 1'b0;
		if (idx == vpl_pkg::REG_CPU_PORT)
			cpu_port_q = value[4:0];
		else
			port_count_q = value;
	endtask

	// all bytes taken and all results back, then let the pipeline settle
	task automatic wait_idle();
		do
			@(posedge clk);
		while (char_stream.size() != 0 || in_valid || masks_due.size() != 0);
		repeat (4) @(posedge clk);
	endtask

	// one string: 0 well formed, 1 with a bad token start, 2 raw noise
	task automatic add_list(int kind);
		int ntok, bad_at, n;
		logic [7:0] c;
		if (kind == 2) begin
			repeat ($urandom_range(1, 20))
				char_stream.push_back(8'($urandom_range(255)));
			char_stream.push_back(vpl_pkg::CH_NUL);
			return;
		end
		ntok = $urandom_range(0, 6);
		bad_at = (kind == 1) ? $urandom_range(0, ntok) : -1;
		if ($urandom_range(3) == 0)
			char_stream.push_back(pick_blank());
		for (int t = 0; t <= ntok; t++) begin
			if (t == bad_at) begin
				do
					c = 8'($urandom_range(1, 255));
				while (is_digit(c) || is_blank(c));
				char_stream.push_back(c);
				char_stream.push_back(pick_blank());
			end
			if (t < ntok) begin
				case ($urandom_range(9))
					0, 1: n = $urandom_range(36, 99999);
					2: n = int'(cpu_port_q);
					default: n = $urandom_range(0, 35);
				endcase
				if ($urandom_range(9) == 0)
					char_stream.push_back(vpl_pkg::CH_ZERO);
				push_text($sformatf("%0d", n));
				repeat ($urandom_range(0, 2))
					char_stream.push_back(pick_suffix());
				if (t < ntok - 1 || $urandom_range(1) == 1) begin
					repeat ($urandom_range(1, 2))
						char_stream.push_back(pick_blank());
				end
			end
		end
		char_stream.push_back(vpl_pkg::CH_NUL);
	endtask

	// program both registers while idle, then stream one phase of strings
	task automatic run_phase(logic [4:0] cpu, logic [5:0] count, bit no_gaps, bit hold_mid);
		int produced, prev_size, r;
		bit held;
		wait_idle();
		cfg_write(vpl_pkg::REG_CPU_PORT, {1'b0, cpu});
		cfg_write(vpl_pkg::REG_PORT_COUNT, count);
		steady = no_gaps;
		@(posedge clk);
		produced = 0;
		held = 1'b0;
		while (produced < PHASE_ITEMS) begin
			r = $urandom_range(99);
			prev_size = char_stream.size();
			add_list(r < 70 ? 0 : (r < 85 ? 1 : 2));
			produced += char_stream.size() - prev_size;
			// sender holds off mid-phase until every result is back
			if (hold_mid && !held && produced >= PHASE_ITEMS / 2) begin
				wait_idle();
				held = 1'b1;
			end
		end
	endtask

	initial begin
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: cpu port tagged by default, suffixes, space, tab and CR blanks
		push_text("0 31*\t9t");
		char_stream.push_back(vpl_pkg::CH_CR);
		push_text("5u");
		char_stream.push_back(vpl_pkg::CH_NUL);
		// empty and blank strings
		char_stream.push_back(vpl_pkg::CH_NUL);
		push_text(" \n");
		char_stream.push_back(vpl_pkg::CH_NUL);
		// saturating number, out of range, ignored suffix
		push_text("99999x");
		char_stream.push_back(vpl_pkg::CH_NUL);
		// bad token start, rest skipped
		char_stream.push_back(8'hff);
		push_text("1");
		char_stream.push_back(vpl_pkg::CH_NUL);

		run_phase(5'd31, 6'd1, 1'b0, 1'b0);
		run_phase(5'd0, 6'd0, 1'b0, 1'b0);
		run_phase(5'd17, 6'd63, 1'b1, 1'b0);
		run_phase(5'd5, 6'd32, 1'b0, 1'b1);
		run_phase(5'($urandom_range(31)), 6'($urandom_range(1, 32)), 1'b0, 1'b0);
		run_phase(5'($urandom_range(31)), 6'($urandom_range(1, 32)), 1'b0, 1'b0);

		wait_idle();
		repeat (16) @(posedge clk);
		while (masks_due.size() != 0) begin
			report("result never returned, member_mask", '0, masks_due[0].member);
			void'(masks_due.pop_front());
		end
		if (mismatches == 0)
			$display("** vlan_port_list_parser_core: PASSED **");
		else
			$display("** vlan_port_list_parser_core: FAILED **");
		$finish;
	end

endmodule
